@@ src/vertex_project_clip_viewport_core_assert.svh @@
// Assertion macros shared by the vertex projection block.
`ifndef VERTEX_PROJECT_CLIP_VIEWPORT_CORE_ASSERT_SVH
`define VERTEX_PROJECT_CLIP_VIEWPORT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VPCV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vpcv: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define VPCV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vpcv: next-cycle check failed");

`endif

@@ src/vpcv_pkg.sv @@
// Package with payload types and fixed constants of the vertex projection block.
`default_nettype none
package vpcv_pkg;

    // Signed width of a clip coordinate in Q.26 (sum of four 48-bit products).
    localparam int CLIP_W = 49;
    localparam int COORD_W = 21;
    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};
    // One Q16.16 LSB expressed in Q.26.
    localparam logic [CLIP_W-1:0] W_EPS = CLIP_W'(1024);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VP_W = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VP_H = 3'd5;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
    } t_vertex;

    typedef struct packed {
        logic [COORD_W-1:0] screen_x;
        logic [COORD_W-1:0] screen_y;
        logic               visible;
    } t_screen;

endpackage
`default_nettype wire

@@ src/vertex_project_clip_viewport_core.sv @@
// Vertex transform, clip test and viewport mapping pipeline.
//
// Usage: a vertex beat (signed Q16.16 x, y, z) is taken at every rising edge where start
// is high and busy is low. busy is always low: the pipeline takes one vertex per clock.
// Each vertex is multiplied by the 4x4 Q5.10 matrix, rejected when |w| is below one
// Q16.16 LSB or when any of x, y, z lies outside the clip volume, and otherwise mapped
// to Q13.8 pixel coordinates with y flipped. A rejected vertex yields visible = 0 and
// zero coordinates.
// Output: the result beat shows on o_screen with o_valid high for one cycle. A vertex
// passes the input register, products, pair sums, clip coordinates, magnitudes, clip
// test, the viewport divider and the output register, in that order. The divider
// retires one bit of the scale factor size*256 per stage, most significant bit first.
// Throughput: one vertex per clock, sustained.
// Results cannot be held off by the receiver; nothing in the pipeline ever stalls.
// Configuration: matrix rows and viewport size are written over the cfg channel,
// which is always ready. Registers must only be written while no vertex is in flight.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix
// with a 640 x 480 viewport.
`default_nettype none
module vertex_project_clip_viewport_core #(
    parameter int VIEWPORT_MAX = 4096
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire vpcv_pkg::t_vertex        i_vertex,
    output logic                          o_valid,
    output vpcv_pkg::t_screen             o_screen,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [vpcv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [63:0]                    i_cfg_data
);
    import vpcv_pkg::*;

    // Width of a saturated viewport size, of the scale factor M = size * 256, and
    // of the quotient, which never exceeds M.
    localparam int SW = $clog2(VIEWPORT_MAX + 1);
    localparam int MW = SW + 8;
    localparam int QW = MW;
    localparam int UW = CLIP_W;
    localparam int RW = UW + 2;

    typedef struct packed {
        logic          vis;
        logic [UW-1:0] d;
        logic [UW-1:0] nx;
        logic [UW-1:0] ny;
        logic [UW-1:0] rx;
        logic [UW-1:0] ry;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
    } t_div;

    // ---------------- configuration registers ----------------
    logic [63:0] r_row [4];
    logic [12:0] r_vp_w;
    logic [12:0] r_vp_h;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= 64'd1024;
            r_row[1] <= 64'd1024 << 16;
            r_row[2] <= 64'd1024 << 32;
            r_row[3] <= 64'd1024 << 48;
            r_vp_w   <= 13'd640;
            r_vp_h   <= 13'd480;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROW0: r_row[0] <= i_cfg_data;
                REG_ROW1: r_row[1] <= i_cfg_data;
                REG_ROW2: r_row[2] <= i_cfg_data;
                REG_ROW3: r_row[3] <= i_cfg_data;
                REG_VP_W: r_vp_w   <= i_cfg_data[12:0];
                REG_VP_H: r_vp_h   <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // VIEWPORT_MAX caps sizes; only the user keeps scale factors fixed while work runs.
    logic [SW-1:0] size_x;
    logic [SW-1:0] size_y;
    logic [MW-1:0] m_x;
    logic [MW-1:0] m_y;

    always_comb begin
        size_x = (32'(r_vp_w) > 32'(VIEWPORT_MAX)) ? SW'(VIEWPORT_MAX) : SW'(r_vp_w);
        size_y = (32'(r_vp_h) > 32'(VIEWPORT_MAX)) ? SW'(VIEWPORT_MAX) : SW'(r_vp_h);
        m_x    = {size_x, 8'h00};
        m_y    = {size_y, 8'h00};
    end

    // ---------------- stage 0: input register ----------------
    logic    r_s0_valid;
    t_vertex r_s0_vtx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= start && !busy;
        end
        r_s0_vtx <= i_vertex;
    end

    // ---------------- stage 1: sixteen products ----------------
    // The w column multiplies 1.0 in Q16.16, which is a plain shift.
    logic               r_s1_valid;
    logic signed [47:0] r_prod [4][4];
    logic signed [47:0] n_prod [4][4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_prod[r][0] = $signed(r_row[r][15:0])  * r_s0_vtx.vertex_x;
            n_prod[r][1] = $signed(r_row[r][31:16]) * r_s0_vtx.vertex_y;
            n_prod[r][2] = $signed(r_row[r][47:32]) * r_s0_vtx.vertex_z;
            n_prod[r][3] = $signed({{16{r_row[r][63]}}, r_row[r][63:48], 16'h0000});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
        r_prod <= n_prod;
    end

    // ---------------- stage 2: pair sums ----------------
    logic                    r_s2_valid;
    logic signed [CLIP_W-1:0] r_pair [4][2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        for (int r = 0; r < 4; r++) begin
            r_pair[r][0] <= CLIP_W'(r_prod[r][0]) + CLIP_W'(r_prod[r][1]);
            r_pair[r][1] <= CLIP_W'(r_prod[r][2]) + CLIP_W'(r_prod[r][3]);
        end
    end

    // ---------------- stage 3: clip coordinates ----------------
    logic                     r_s3_valid;
    logic signed [CLIP_W-1:0] r_clip [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        for (int r = 0; r < 4; r++) begin
            r_clip[r] <= r_pair[r][0] + r_pair[r][1];
        end
    end

    // ---------------- stage 4: magnitudes and sign fold ----------------
    // A negative w flips the signs of w and the x, y numerators together.
    logic                     r_s4_valid;
    logic [UW-1:0]            r_s4_aw;
    logic [UW-1:0]            r_s4_ax;
    logic [UW-1:0]            r_s4_ay;
    logic [UW-1:0]            r_s4_az;
    logic signed [CLIP_W-1:0] r_s4_fx;
    logic signed [CLIP_W-1:0] r_s4_fy;
    logic                     w_neg;

    assign w_neg = r_clip[3][CLIP_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
        r_s4_aw <= w_neg ? UW'(-r_clip[3]) : UW'(r_clip[3]);
        r_s4_ax <= r_clip[0][CLIP_W-1] ? UW'(-r_clip[0]) : UW'(r_clip[0]);
        r_s4_ay <= r_clip[1][CLIP_W-1] ? UW'(-r_clip[1]) : UW'(r_clip[1]);
        r_s4_az <= r_clip[2][CLIP_W-1] ? UW'(-r_clip[2]) : UW'(r_clip[2]);
        r_s4_fx <= w_neg ? -r_clip[0] : r_clip[0];
        r_s4_fy <= w_neg ? -r_clip[1] : r_clip[1];
    end

    // ---------------- stage 5: clip test, numerators, divider entry ----------------
    logic [MW:0] r_dv_valid;
    t_div        r_div [MW+1];
    t_div        n_div0;

    always_comb begin
        n_div0     = '0;
        n_div0.vis = (r_s4_aw >= W_EPS) && (r_s4_ax <= r_s4_aw) &&
                     (r_s4_ay <= r_s4_aw) && (r_s4_az <= r_s4_aw);
        n_div0.d   = UW'({r_s4_aw, 1'b0});
        n_div0.nx  = UW'(r_s4_fx + $signed(r_s4_aw));
        n_div0.ny  = UW'($signed(r_s4_aw) - r_s4_fy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else begin
            r_dv_valid[0] <= r_s4_valid;
        end
        r_div[0] <= n_div0;
    end

    // One long-division step: the remainder doubles, takes n when the current bit of
    // M is set, and loses d up to twice. Returns {quotient increment, remainder}.
    function automatic logic [UW+1:0] div_step(
        input logic [UW-1:0] rem,
        input logic [UW-1:0] num,
        input logic [UW-1:0] den,
        input logic          mbit
    );
        logic [RW-1:0] t;
        logic [RW-1:0] d1;
        logic [RW-1:0] d2;
        t  = {1'b0, rem, 1'b0} + (mbit ? RW'(num) : '0);
        d1 = RW'(den);
        d2 = RW'({den, 1'b0});
        if (t >= d2) begin
            return {2'd2, UW'(t - d2)};
        end else if (t >= d1) begin
            return {2'd1, UW'(t - d1)};
        end else begin
            return {2'd0, UW'(t)};
        end
    endfunction

    // ---------------- divider stages, most significant bit of M first ----------------
    for (genvar g = 0; g < MW; g++) begin : g_div
        logic [UW+1:0] step_x;
        logic [UW+1:0] step_y;
        t_div          nxt;

        always_comb begin
            step_x   = div_step(r_div[g].rx, r_div[g].nx, r_div[g].d, m_x[MW-1-g]);
            step_y   = div_step(r_div[g].ry, r_div[g].ny, r_div[g].d, m_y[MW-1-g]);
            nxt      = r_div[g];
            nxt.rx   = step_x[UW-1:0];
            nxt.ry   = step_y[UW-1:0];
            nxt.qx   = {r_div[g].qx[QW-2:0], 1'b0} + QW'(step_x[UW+1:UW]);
            nxt.qy   = {r_div[g].qy[QW-2:0], 1'b0} + QW'(step_y[UW+1:UW]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[g+1] <= 1'b0;
            end else begin
                r_dv_valid[g+1] <= r_dv_valid[g];
            end
            r_div[g+1] <= nxt;
        end
    end

    // ---------------- output register ----------------
    logic    r_out_valid;
    t_screen r_out;
    t_screen n_out;

    always_comb begin
        n_out = '0;
        if (r_div[MW].vis) begin
            n_out.visible  = 1'b1;
            n_out.screen_x = (32'(r_div[MW].qx) > 32'(COORD_MAX)) ? COORD_MAX
                                                                   : COORD_W'(r_div[MW].qx);
            n_out.screen_y = (32'(r_div[MW].qy) > 32'(COORD_MAX)) ? COORD_MAX
                                                                   : COORD_W'(r_div[MW].qy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_dv_valid[MW];
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_screen = r_out;

    // ---------------- checks ----------------
`include "vertex_project_clip_viewport_core_assert.svh"

    `VPCV_ASSERT_NOW(a_hidden_is_zero, r_out_valid && !r_out.visible,
        r_out.screen_x == '0 && r_out.screen_y == '0)
    `VPCV_ASSERT_NOW(a_visible_has_divisor, r_dv_valid[0] && r_div[0].vis,
        r_div[0].d >= UW'(2048) && r_div[0].nx <= r_div[0].d && r_div[0].ny <= r_div[0].d)
    `VPCV_ASSERT_NEXT(a_tail_reaches_out, r_dv_valid[MW] && r_div[MW].vis,
        r_out_valid && r_out.visible)
    `VPCV_ASSERT_NOW(a_remainder_bound, r_dv_valid[MW] && r_div[MW].vis,
        r_div[MW].rx < r_div[MW].d && r_div[MW].ry < r_div[MW].d)

endmodule
`default_nettype wire

@@ tb/vpcv_checker.sv @@
// Checker that predicts and compares the vertex projection results.
`default_nettype none
module vpcv_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wire                 busy,
    input  wire vpcv_pkg::t_vertex i_vertex,
    input  wire                 o_valid,
    input  wire vpcv_pkg::t_screen o_screen,
    input  wire                 i_cfg_valid,
    input  wire                 o_cfg_ready,
    input  wire [2:0]           i_cfg_index,
    input  wire [63:0]          i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_visible_count,
    output int                  o_result_count
);
    import vpcv_pkg::*;

    logic [63:0] mat_row [4];
    logic [12:0] vp_w, vp_h;
    t_screen     screen_queue [$];

    function automatic logic signed [63:0] entry(logic [63:0] row, int col);
        logic signed [15:0] e;
        e = row[16*col +: 16];
        return 64'(e);
    endfunction

    function automatic logic signed [63:0] dot_row(logic [63:0] row,
            logic signed [63:0] x, logic signed [63:0] y, logic signed [63:0] z);
        return entry(row, 0) * x + entry(row, 1) * y + entry(row, 2) * z
            + entry(row, 3) * 64'sd65536;
    endfunction

    // floor(num * size * 256 / (2 * w)), size clamped to the viewport limit.
    function automatic logic [20:0] pixel_coord(logic [63:0] num, logic [63:0] w,
            logic [12:0] size);
        logic [127:0] q;
        logic [63:0]  s;
        s = (size > 13'd4096) ? 64'd4096 : 64'(size);
        q = (128'(num) * 128'(s) * 128'd256) / (128'(w) * 128'd2);
        return (q > 128'(COORD_MAX)) ? COORD_MAX : q[20:0];
    endfunction

    function automatic t_screen project_vertex(t_vertex v);
        logic signed [63:0] x, y, z, cx, cy, cz, cw, aw;
        t_screen r;
        x = 64'(v.vertex_x);
        y = 64'(v.vertex_y);
        z = 64'(v.vertex_z);
        cx = dot_row(mat_row[0], x, y, z);
        cy = dot_row(mat_row[1], x, y, z);
        cz = dot_row(mat_row[2], x, y, z);
        cw = dot_row(mat_row[3], x, y, z);
        aw = cw < 0 ? -cw : cw;
        r = '0;
        if (aw < 1024) return r;
        if ((cx < 0 ? -cx : cx) > aw || (cy < 0 ? -cy : cy) > aw
                || (cz < 0 ? -cz : cz) > aw) return r;
        if (cw < 0) begin
            cw = -cw;
            cx = -cx;
            cy = -cy;
        end
        r.screen_x = pixel_coord(cx + cw, cw, vp_w);
        r.screen_y = pixel_coord(cw - cy, cw, vp_h);
        r.visible = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_screen want;
        if (!i_rst_n) begin
            mat_row[0] <= 64'd1024;
            mat_row[1] <= 64'd1024 << 16;
            mat_row[2] <= 64'd1024 << 32;
            mat_row[3] <= 64'd1024 << 48;
            vp_w <= 13'd640;
            vp_h <= 13'd480;
            screen_queue.delete();
            o_fail_count <= 0;
            o_visible_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROW0: mat_row[0] <= i_cfg_data;
                    REG_ROW1: mat_row[1] <= i_cfg_data;
                    REG_ROW2: mat_row[2] <= i_cfg_data;
                    REG_ROW3: mat_row[3] <= i_cfg_data;
                    REG_VP_W: vp_w <= i_cfg_data[12:0];
                    REG_VP_H: vp_h <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (start && !busy) screen_queue.push_back(project_vertex(i_vertex));
            if (o_valid) begin
                o_result_count <= o_result_count + 1;
                if (screen_queue.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result beat %p", o_screen);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = screen_queue.pop_front();
                    if (want.visible) o_visible_count <= o_visible_count + 1;
                    if (want !== o_screen) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: expected x=%0d y=%0d vis=%0d,",
                                      " got x=%0d y=%0d vis=%0d"},
                                want.screen_x, want.screen_y, want.visible,
                                o_screen.screen_x, o_screen.screen_y, o_screen.visible);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = screen_queue.size();
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Top of the vertex projection testbench: stimulus, configuration and verdict.
`default_nettype none
module tb_top;
    import vpcv_pkg::*;

    // Extra wait that drain adds once no result is outstanding.
    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_vertex     i_vertex = '0;
    logic        o_valid;
    t_screen     o_screen;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = REG_ROW0;
    logic [63:0] i_cfg_data = '0;
    int          fail_count, pending, visible_count, result_count;
    int          idle_cycles = 0;
    int          idle_pct = 36;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    vertex_project_clip_viewport_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_vertex(i_vertex), .o_valid(o_valid), .o_screen(o_screen),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    vpcv_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_vertex(i_vertex), .o_valid(o_valid), .o_screen(o_screen),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_visible_count(visible_count), .o_result_count(result_count)
    );

    // The watchdog counts cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("FAIL");
            $finish;
        end
    end

    // Write one register; the channel holds valid until the handshake completes,
    // then stays low for one cycle so that back-to-back writes are separate beats.
    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Send one vertex beat, with a random idle gap ahead of it. Start stays
    // high between back-to-back beats and is only lowered for a gap.
    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_vertex <= '{vertex_x: x, vertex_y: y, vertex_z: z};
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Let the pipeline empty before touching the registers again.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // A matrix row with small Q5.10 entries, which keeps many vertices in view.
    function automatic logic [63:0] mild_row(int diag_col);
        logic [63:0] r;
        for (int c = 0; c < 4; c++) begin
            logic [15:0] e;
            e = 16'($signed($urandom_range(600, 0)) - 300);
            if (c == diag_col) e = 16'($urandom_range(2048, 256));
            r[16*c +: 16] = e;
        end
        return r;
    endfunction

    // A vertex near the unit cube, in Q16.16.
    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(150000, 0)) - 75000);
    endfunction

    initial begin
        logic [31:0] extremes [6];
        extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                     32'h0001_0000, 32'hFFFF_0000};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: identity matrix, 640 x 480 viewport, reset values.
        send_vertex(32'h0, 32'h0, 32'h0);
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_vertex(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        send_vertex(32'h0001_0001, 32'h0, 32'h0);
        foreach (extremes[i]) send_vertex(extremes[i], extremes[(i+1)%6], extremes[(i+2)%6]);
        drain_pipeline();

        // Negated w row: a negative w flips the signs of w and the x, y numerators together.
        write_reg(REG_ROW3, 64'hFC00_0000_0000_0000);
        send_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0);
        send_vertex(32'h0001_0000, 32'h0, 32'h0);
        drain_pipeline();

        // w from z alone: z near zero makes w degenerate.
        write_reg(REG_ROW3, 64'h0000_0400_0000_0000);
        send_vertex(32'h0, 32'h0, 32'h0);
        send_vertex(32'h0, 32'h0, 32'h0000_0001);
        send_vertex(32'h0, 32'h0, 32'h0000_0040);
        send_vertex(32'h0000_1000, 32'hFFFF_F000, 32'h0001_0000);
        drain_pipeline();

        // Viewport extremes: zero, one, the largest legal, and above the limit.
        write_reg(REG_ROW3, 64'h0400_0000_0000_0000);
        write_reg(REG_VP_W, 64'd0);
        write_reg(REG_VP_H, 64'd1);
        send_vertex(32'h0000_4000, 32'h0000_4000, 32'h0);
        drain_pipeline();
        write_reg(REG_VP_W, 64'd4096);
        write_reg(REG_VP_H, 64'h1FFF);
        send_vertex(32'h0000_4000, 32'hFFFF_C000, 32'h0);
        send_vertex(32'hFFFF_0000, 32'h0001_0000, 32'h0);
        drain_pipeline();

        // Random phases: each loads a fresh matrix and viewport, then streams
        // vertices. Most rows are mild so that many vertices land on screen;
        // some phases use fully random bits.
        for (int phase = 0; phase < 20; phase++) begin
            logic wild;
            wild = (phase % 5 == 4);
            for (int r = 0; r < 4; r++)
                write_reg(3'(r), wild ? {$urandom, $urandom} : mild_row(r));
            write_reg(REG_VP_W, (phase == 0) ? 64'd1 : 64'($urandom_range(4096, 1)));
            write_reg(REG_VP_H, (phase == 1) ? 64'd4096 : 64'($urandom_range(4096, 1)));
            // One phase in four streams without any gaps.
            idle_pct = (phase % 4 == 3) ? 0 : 36;
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(9, 0) < 8)
                    send_vertex(near_coord(), near_coord(), near_coord());
                else
                    send_vertex($urandom, $urandom, $urandom);
            end
            drain_pipeline();
        end

        $display({"Checked %0d vertices, %0d visible, across directed",
                  " and 20 random matrix setups."}, result_count, visible_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
